// File: rtl/gaussian_spot_pixel_generator_macros.svh
// ----------------------------------------------------------------------------
// Gaussian spot pixel generator - assertion macros
// Concurrent assertion wrappers; define ASSERT_OFF to compile them out.
// ----------------------------------------------------------------------------
`ifndef GAUSSIAN_SPOT_PIXEL_GENERATOR_MACROS_SVH
`define GAUSSIAN_SPOT_PIXEL_GENERATOR_MACROS_SVH

`ifndef ASSERT_OFF
`define GSP_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("gsp assertion failed");
`define GSP_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("gsp assertion failed");
`else
`define GSP_ASSERT(label, clk, rst_n, prop)
`define GSP_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

// File: rtl/gsp_pkg.sv
// ----------------------------------------------------------------------------
// gsp_pkg
// Types, widths, register indexes and exp tables for the Gaussian spot
// pixel generator.
// ----------------------------------------------------------------------------
package gsp_pkg;

    localparam int unsigned COORD_W = 10;
    localparam int unsigned SIZE_W  = 11;
    localparam int unsigned FALL_W  = 32;
    localparam int unsigned PIX_W   = 8;
    localparam int unsigned SUM_W   = 21;
    localparam int unsigned E_W     = SUM_W + FALL_W;
    localparam int unsigned EX_W    = 27;   // 3 integer bits, 24 fraction bits
    localparam int unsigned Q16_W   = 17;
    localparam int unsigned DIFF_W  = 12;
    localparam int unsigned P_W     = 2 * Q16_W;
    localparam int unsigned CFG_W   = 32;
    localparam int unsigned CIDX_W  = 1;

    localparam logic [CIDX_W-1:0] REG_IMAGE_SIZE = 1'b0;
    localparam logic [CIDX_W-1:0] REG_FALLOFF    = 1'b1;

    localparam logic [SIZE_W-1:0] SIZE_RESET    = 11'd512;
    localparam logic [FALL_W-1:0] FALLOFF_RESET = 32'd20972;

    typedef struct packed {
        logic            oor;
        logic            big;
        logic [EX_W-1:0] e;
    } t_exp_in;

    // exp(-i), Q16
    function automatic logic [Q16_W-1:0] exp_int(input logic [2:0] i);
        logic [Q16_W-1:0] v;
        unique case (i)
            3'd0: v = 17'd65536;
            3'd1: v = 17'd24109;
            3'd2: v = 17'd8869;
            3'd3: v = 17'd3263;
            3'd4: v = 17'd1200;
            3'd5: v = 17'd442;
            3'd6: v = 17'd162;
            3'd7: v = 17'd60;
        endcase
        return v;
    endfunction

    // exp(-k/16), Q16
    function automatic logic [Q16_W-1:0] exp_frac(input logic [4:0] k);
        logic [Q16_W-1:0] v;
        case (k)
            5'd0:    v = 17'd65536;
            5'd1:    v = 17'd61565;
            5'd2:    v = 17'd57835;
            5'd3:    v = 17'd54331;
            5'd4:    v = 17'd51039;
            5'd5:    v = 17'd47947;
            5'd6:    v = 17'd45042;
            5'd7:    v = 17'd42313;
            5'd8:    v = 17'd39750;
            5'd9:    v = 17'd37341;
            5'd10:   v = 17'd35079;
            5'd11:   v = 17'd32954;
            5'd12:   v = 17'd30957;
            5'd13:   v = 17'd29081;
            5'd14:   v = 17'd27319;
            5'd15:   v = 17'd25664;
            default: v = 17'd24109;
        endcase
        return v;
    endfunction

endpackage

// File: rtl/gaussian_spot_pixel_generator.sv
// ----------------------------------------------------------------------------
// gaussian_spot_pixel_generator
// Per-pixel intensity of a centred 2D Gaussian spot on a square image.
// ----------------------------------------------------------------------------
// Takes one (row, col) transaction per clock while o_ready is high and
// returns round(255*exp(-e)) with e = ((col - S/2)^2 + (row - S/2)^2) *
// falloff, S the image size (capped at MAX_SIZE and at 2047). Six register
// stages: offsets, squares, falloff product, exp lookup and interpolation,
// product of exp terms, scaling. Throughput is one pixel per clock while the
// output is not stalled. Each stage holds its item while the next is full,
// so a stalled output only blocks once the pipeline fills.
// Coordinates not below S give 0 with o_out_of_range set. Configuration
// writes take effect at once and are meant to happen only while idle.
// ----------------------------------------------------------------------------
`include "gaussian_spot_pixel_generator_macros.svh"

module gaussian_spot_pixel_generator
    import gsp_pkg::*;
#(
    parameter int unsigned MAX_SIZE = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [CIDX_W-1:0]  i_cfg_index,
    input  logic [CFG_W-1:0]   i_cfg_data,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [COORD_W-1:0] i_row,
    input  logic [COORD_W-1:0] i_col,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [PIX_W-1:0]   o_pixel_value,
    output logic               o_out_of_range
);

    localparam int unsigned SizeCap = (MAX_SIZE > 2047) ? 2047 : MAX_SIZE;
    localparam logic [SIZE_W-1:0] SizeCapV = SIZE_W'(SizeCap);

    logic [SIZE_W-1:0] r_image_size;
    logic [FALL_W-1:0] r_falloff;

    logic               r_v1, r_v2, r_v3;
    logic               w_en1, w_en2, w_en3;
    logic               w_exp_ready;

    logic               r_oor1, r_oor2;
    logic [COORD_W-1:0] r_dx, r_dy;
    logic [SUM_W-1:0]   r_sum;
    t_exp_in            r_x3;

    logic [SIZE_W-1:0]    w_size, w_half, w_row, w_col, w_dx, w_dy;
    logic                 w_oor;
    logic [2*COORD_W-1:0] w_sq_x, w_sq_y;
    logic [E_W-1:0]       w_e;
    t_exp_in              n_x3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_size <= SIZE_RESET;
            r_falloff    <= FALLOFF_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_IMAGE_SIZE: r_image_size <= i_cfg_data[SIZE_W-1:0];
                REG_FALLOFF:    r_falloff    <= i_cfg_data[FALL_W-1:0];
            endcase
        end
    end

    assign w_size = (r_image_size > SizeCapV) ? SizeCapV : r_image_size;
    assign w_half = w_size >> 1;
    assign w_row  = {1'b0, i_row};
    assign w_col  = {1'b0, i_col};
    assign w_oor  = (w_row >= w_size) || (w_col >= w_size);
    assign w_dx   = (w_col >= w_half) ? (w_col - w_half) : (w_half - w_col);
    assign w_dy   = (w_row >= w_half) ? (w_row - w_half) : (w_half - w_row);

    assign w_sq_x = {{COORD_W{1'b0}}, r_dx} * {{COORD_W{1'b0}}, r_dx};
    assign w_sq_y = {{COORD_W{1'b0}}, r_dy} * {{COORD_W{1'b0}}, r_dy};

    assign w_e       = {{(E_W-SUM_W){1'b0}}, r_sum} * {{(E_W-FALL_W){1'b0}}, r_falloff};
    assign n_x3.oor  = r_oor2;
    assign n_x3.big  = |w_e[E_W-1:EX_W];
    assign n_x3.e    = w_e[EX_W-1:0];

    assign w_en3   = !r_v3 || w_exp_ready;
    assign w_en2   = !r_v2 || w_en3;
    assign w_en1   = !r_v1 || w_en2;
    assign o_ready = w_en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_en1) r_v1 <= i_valid;
            if (w_en2) r_v2 <= r_v1;
            if (w_en3) r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en1 && i_valid) begin
            r_oor1 <= w_oor;
            r_dx   <= w_dx[COORD_W-1:0];
            r_dy   <= w_dy[COORD_W-1:0];
        end
        if (w_en2 && r_v1) begin
            r_oor2 <= r_oor1;
            r_sum  <= {1'b0, w_sq_x} + {1'b0, w_sq_y};
        end
        if (w_en3 && r_v2) begin
            r_x3 <= n_x3;
        end
    end

    gsp_exp u_exp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (r_v3),
        .o_ready        (w_exp_ready),
        .i_data         (r_x3),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_pixel_value  (o_pixel_value),
        .o_out_of_range (o_out_of_range)
    );

    `GSP_ASSERT(a_oor_zero, i_clk, i_rst_n, o_valid && o_out_of_range |-> o_pixel_value == 8'd0)
    `GSP_ASSERT(a_ready_full, i_clk, i_rst_n, !o_ready |-> r_v1 && r_v2 && r_v3 && !w_exp_ready)
    `GSP_ASSERT(a_sum_bound, i_clk, i_rst_n, r_v2 && !r_oor2 |-> r_sum <= 21'd2093058)

endmodule

// File: rtl/gsp_exp.sv
// ----------------------------------------------------------------------------
// gsp_exp
// Three-stage exp(-e) evaluation: table lookup and interpolation, product
// of integer and fraction terms, scaling to an 8-bit intensity.
// ----------------------------------------------------------------------------
`include "gaussian_spot_pixel_generator_macros.svh"

module gsp_exp
    import gsp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  t_exp_in          i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [PIX_W-1:0] o_pixel_value,
    output logic             o_out_of_range
);

    logic             r_v4, r_v5, r_v6;
    logic             w_en4, w_en5, w_en6;

    logic [Q16_W-1:0] r_ef, r_ei;
    logic             r_zero4, r_oor4;
    logic [P_W-1:0]   r_p;
    logic             r_zero5, r_oor5;
    logic [PIX_W-1:0] r_pix;
    logic             r_oor6;

    logic [2:0]        w_i;
    logic [3:0]        w_k;
    logic [19:0]       w_r;
    logic [Q16_W-1:0]  w_lo, w_hi, w_diff_full, w_ef;
    logic [DIFF_W-1:0] w_diff;
    logic [31:0]       w_corr_prod;
    logic [P_W+8:0]    w_round;
    logic [10:0]       w_v;
    logic [PIX_W-1:0]  n_pix;

    assign w_en6   = !r_v6 || i_ready;
    assign w_en5   = !r_v5 || w_en6;
    assign w_en4   = !r_v4 || w_en5;
    assign o_ready = w_en4;

    // stage 4: lookups and interpolation
    assign w_i         = i_data.e[26:24];
    assign w_k         = i_data.e[23:20];
    assign w_r         = i_data.e[19:0];
    assign w_lo        = exp_frac({1'b0, w_k});
    assign w_hi        = exp_frac({1'b0, w_k} + 5'd1);
    assign w_diff_full = w_lo - w_hi;
    assign w_diff      = w_diff_full[DIFF_W-1:0];
    assign w_corr_prod = {20'd0, w_diff} * {12'd0, w_r};
    assign w_ef        = w_lo - {5'd0, w_corr_prod[31:20]};

    // stage 6: 255 * p, round half up, keep integer part
    assign w_round = {1'b0, r_p, 8'd0} - {9'd0, r_p} + (43'd1 << 31);
    assign w_v     = w_round[P_W+8:32];

    always_comb begin
        priority if (r_zero5 || r_oor5) begin
            n_pix = '0;
        end else if (w_v > 11'd255) begin
            n_pix = 8'd255;
        end else begin
            n_pix = w_v[PIX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else begin
            if (w_en4) r_v4 <= i_valid;
            if (w_en5) r_v5 <= r_v4;
            if (w_en6) r_v6 <= r_v5;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en4 && i_valid) begin
            r_ef    <= w_ef;
            r_ei    <= exp_int(w_i);
            r_zero4 <= i_data.big;
            r_oor4  <= i_data.oor;
        end
        if (w_en5 && r_v4) begin
            r_p     <= {{(P_W-Q16_W){1'b0}}, r_ef} * {{(P_W-Q16_W){1'b0}}, r_ei};
            r_zero5 <= r_zero4;
            r_oor5  <= r_oor4;
        end
        if (w_en6 && r_v5) begin
            r_pix  <= n_pix;
            r_oor6 <= r_oor5;
        end
    end

    assign o_valid        = r_v6;
    assign o_pixel_value  = r_pix;
    assign o_out_of_range = r_oor6;

    `GSP_ASSERT(a_ef_range, i_clk, i_rst_n, r_v4 && !r_zero4 && !r_oor4 |-> (r_ef <= 17'd65536) && (r_ef >= 17'd24109))
    `GSP_ASSERT(a_p_bound, i_clk, i_rst_n, r_v5 |-> r_p <= 34'h1_0000_0000)
    `GSP_ASSERT(a_s5_hold, i_clk, i_rst_n, r_v5 && !w_en5 |=> r_v5 && $stable(r_p))

endmodule

// File: test/gaussian_spot_pixel_generator_tb.sv
// ----------------------------------------------------------------------------
// gaussian_spot_pixel_generator_tb
// Self-checking bench for the Gaussian spot pixel generator. A local model of
// the fixed-point exp datapath predicts every pixel transaction as it is
// accepted; each output transaction is checked field by field, in order.
// Directed tests cover reset defaults, image size and falloff extremes and
// the e >= 8 cut-off; random phases then sweep sizes and falloffs with
// random stalls on both sides, followed by a back-to-back streaming run.
// ----------------------------------------------------------------------------
module gaussian_spot_pixel_generator_tb;
    import gsp_pkg::*;

    localparam int unsigned     MAX_SIDE    = 1024;
    localparam longint unsigned E_CUTOFF    = 64'd8 << 24;
    localparam int unsigned     CYCLE_LIMIT = 400000;
    localparam int unsigned     TBL_W       = 17;

    // exp(-i) and exp(-k/16) in Q16, entry 0 in the low bits
    localparam logic [8*TBL_W-1:0] EXP_WHOLE_TBL = {
        17'd60, 17'd162, 17'd442, 17'd1200,
        17'd3263, 17'd8869, 17'd24109, 17'd65536
    };
    localparam logic [17*TBL_W-1:0] EXP_SEG_TBL = {
        17'd24109,
        17'd25664, 17'd27319, 17'd29081, 17'd30957,
        17'd32954, 17'd35079, 17'd37341, 17'd39750,
        17'd42313, 17'd45042, 17'd47947, 17'd51039,
        17'd54331, 17'd57835, 17'd61565, 17'd65536
    };

    typedef struct packed {
        logic [PIX_W-1:0] value;
        logic             oor;
    } t_spot_pix;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [CIDX_W-1:0]  i_cfg_index;
    logic [CFG_W-1:0]   i_cfg_data;
    logic               i_valid;
    logic               o_ready;
    logic [COORD_W-1:0] i_row;
    logic [COORD_W-1:0] i_col;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic [PIX_W-1:0]   o_pixel_value;
    logic               o_out_of_range;

    logic [SIZE_W-1:0]  side_cfg = SIZE_RESET;
    logic [FALL_W-1:0]  falloff_cfg = FALLOFF_RESET;
    t_spot_pix          pending_pixels[$];
    bit                 no_idle = 1'b0;
    int unsigned        n_errors = 0;
    int unsigned        n_sent = 0;
    int unsigned        n_checked = 0;
    int unsigned        n_oor = 0;
    int unsigned        n_configs = 0;
    int unsigned        cycles = 0;

    gaussian_spot_pixel_generator u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_row          (i_row),
        .i_col          (i_col),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_pixel_value  (o_pixel_value),
        .o_out_of_range (o_out_of_range)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_spot_pix spot_intensity(input logic [COORD_W-1:0] row,
                                                 input logic [COORD_W-1:0] col);
        t_spot_pix       res;
        longint unsigned side, half, dx, dy, e, lo, hi, ef, p, v;
        int unsigned     whole, seg, rem;
        res  = '0;
        side = (side_cfg > MAX_SIDE) ? 64'(MAX_SIDE) : 64'(side_cfg);
        if (64'(row) >= side || 64'(col) >= side) begin
            res.oor = 1'b1;
            return res;
        end
        half = side >> 1;
        dx   = (64'(col) >= half) ? 64'(col) - half : half - 64'(col);
        dy   = (64'(row) >= half) ? 64'(row) - half : half - 64'(row);
        e    = (dx * dx + dy * dy) * 64'(falloff_cfg);
        if (e >= E_CUTOFF)
            return res;
        whole = 32'((e >> 24) & 64'd7);
        seg   = 32'((e >> 20) & 64'd15);
        rem   = 32'(e & 64'hF_FFFF);
        lo    = 64'(EXP_SEG_TBL[seg*TBL_W +: TBL_W]);
        hi    = 64'(EXP_SEG_TBL[(seg+1)*TBL_W +: TBL_W]);
        ef    = lo - (((lo - hi) * 64'(rem)) >> 20);
        p     = ef * 64'(EXP_WHOLE_TBL[whole*TBL_W +: TBL_W]);
        v     = (64'd255 * p + (64'd1 << 31)) >> 32;
        if (v > 255)
            v = 255;
        res.value = v[PIX_W-1:0];
        return res;
    endfunction

    always @(posedge i_clk) begin
        i_ready <= no_idle || ($urandom_range(99) >= 10);
    end

    always @(posedge i_clk) begin : scoreboard
        t_spot_pix want;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d transactions outstanding", $time,
                     pending_pixels.size());
            $display("TB_ERROR");
            $finish;
        end else if (i_rst_n) begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_IMAGE_SIZE: side_cfg = i_cfg_data[SIZE_W-1:0];
                    REG_FALLOFF:    falloff_cfg = i_cfg_data[FALL_W-1:0];
                    default: ;
                endcase
            end
            if (i_valid && o_ready)
                pending_pixels.insert(pending_pixels.size(), spot_intensity(i_row, i_col));
            if (o_valid && i_ready) begin
                n_checked++;
                if (pending_pixels.size() == 0) begin
                    n_errors++;
                    $display("%0t: unexpected result pixel=%0d oor=%0b", $time,
                             o_pixel_value, o_out_of_range);
                end else begin
                    want = pending_pixels.pop_front();
                    if (want.oor)
                        n_oor++;
                    if (o_pixel_value !== want.value) begin
                        n_errors++;
                        $display("%0t: pixel_value expected %0d actual %0d", $time,
                                 want.value, o_pixel_value);
                    end
                    if (o_out_of_range !== want.oor) begin
                        n_errors++;
                        $display("%0t: out_of_range expected %0b actual %0b", $time,
                                 want.oor, o_out_of_range);
                    end
                end
            end
        end
    end

    task automatic send_pixel(input logic [COORD_W-1:0] row,
                              input logic [COORD_W-1:0] col);
        i_valid <= 1'b1;
        i_row   <= row;
        i_col   <= col;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        n_sent++;
        if (!no_idle && $urandom_range(99) < 10) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_pixels.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic load_config(input logic [SIZE_W-1:0] side,
                               input logic [FALL_W-1:0] fall);
        logic [CFG_W-1:0] word;
        wait_idle();
        word = $urandom;
        word[SIZE_W-1:0] = side;
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_IMAGE_SIZE;
        i_cfg_data  <= word;
        @(posedge i_clk);
        i_cfg_index <= REG_FALLOFF;
        i_cfg_data  <= fall;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        n_configs++;
    endtask

    // random falloff scaled so that e spans at most roughly 0..10 across the image
    function automatic logic [FALL_W-1:0] spread_falloff(input logic [SIZE_W-1:0] side);
        longint unsigned half, reach;
        half  = ((side > MAX_SIDE) ? 64'(MAX_SIDE) : 64'(side)) / 2 + 1;
        reach = 2 * half * half;
        return $urandom_range(0, 32'(64'(32'd10 << 24) / reach));
    endfunction

    task automatic test_reset_defaults();
        send_pixel(10'd256, 10'd256);
        send_pixel(10'd0, 10'd0);
        send_pixel(10'd511, 10'd511);
        send_pixel(10'd0, 10'd256);
        send_pixel(10'd256, 10'd0);
        send_pixel(10'd512, 10'd0);
        send_pixel(10'd0, 10'd512);
        send_pixel(10'd1023, 10'd1023);
    endtask

    task automatic test_size_extremes();
        load_config(11'd0, FALLOFF_RESET);
        send_pixel(10'd0, 10'd0);
        load_config(11'd1, FALLOFF_RESET);
        send_pixel(10'd0, 10'd0);
        send_pixel(10'd0, 10'd1);
        load_config(11'd2047, FALLOFF_RESET);
        send_pixel(10'd1023, 10'd1023);
        send_pixel(10'd512, 10'd512);
        load_config(11'd1025, FALLOFF_RESET);
        send_pixel(10'd0, 10'd1023);
        load_config(11'd3, 32'h0100_0000);
        send_pixel(10'd1, 10'd1);
        send_pixel(10'd2, 10'd2);
    endtask

    task automatic test_falloff_extremes();
        load_config(11'd1024, 32'd0);
        send_pixel(10'd0, 10'd0);
        send_pixel(10'd1023, 10'd0);
        load_config(11'd1024, 32'hFFFF_FFFF);
        send_pixel(10'd512, 10'd512);
        send_pixel(10'd512, 10'd513);
        load_config(11'd16, 32'd8 << 24);
        send_pixel(10'd8, 10'd9);
        load_config(11'd16, (32'd8 << 24) - 1);
        send_pixel(10'd8, 10'd9);
        send_pixel(10'd7, 10'd7);
        load_config(11'd16, (32'd1 << 24) - 1);
        send_pixel(10'd8, 10'd9);
    endtask

    task automatic random_batch(input int unsigned count);
        logic [SIZE_W-1:0]  side;
        logic [COORD_W-1:0] row, col;
        int unsigned        span;
        side = (side_cfg > MAX_SIDE) ? SIZE_W'(MAX_SIDE) : side_cfg;
        span = (side == 0) ? 1 : 32'(side);
        repeat (count) begin
            if (side != 0 && $urandom_range(99) < 85) begin
                row = COORD_W'($urandom_range(0, span - 1));
                col = COORD_W'($urandom_range(0, span - 1));
            end else begin
                row = COORD_W'($urandom_range(0, 1023));
                col = COORD_W'($urandom_range(0, 1023));
            end
            send_pixel(row, col);
        end
    endtask

    task automatic test_random_phases();
        logic [SIZE_W-1:0] side;
        logic [FALL_W-1:0] fall;
        for (int ph = 0; ph < 10; ph++) begin
            case ($urandom_range(9))
                0:       side = SIZE_W'($urandom_range(1025, 2047));
                1:       side = 11'd1024;
                2:       side = SIZE_W'($urandom_range(1, 8));
                default: side = SIZE_W'($urandom_range(16, 1024));
            endcase
            case ($urandom_range(19))
                0, 1, 2: fall = $urandom;
                3, 4, 5: fall = $urandom_range(0, 255);
                default: fall = spread_falloff(side);
            endcase
            load_config(side, fall);
            random_batch(135);
        end
    endtask

    task automatic test_streaming();
        load_config(11'd1024, spread_falloff(11'd1024));
        no_idle = 1'b1;
        random_batch(200);
        wait_idle();
        no_idle = 1'b0;
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = REG_IMAGE_SIZE;
        i_cfg_data  = '0;
        i_valid     = 1'b0;
        i_row       = '0;
        i_col       = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_defaults();
        test_size_extremes();
        test_falloff_extremes();
        test_random_phases();
        test_streaming();
        wait_idle();
        $display("Sent %0d pixel transactions over %0d register settings", n_sent,
                 n_configs);
        $display("Checked %0d results, %0d out of range, %0d mismatches", n_checked,
                 n_oor, n_errors);
        if (n_errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
